FILE: hdl/gbs_pkg.sv
// Shared constants, types and helper functions for the greedy box suppression unit.
package gbs_pkg;

	localparam int MAX_KEPT   = 64;
	localparam int COORD_BITS = 16;

	localparam int EDGE_W = 16;
	localparam int DIM_W  = 15;
	localparam int SLOT_W = 6;
	localparam int THR_W  = 16;

	localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W = $clog2(MAX_KEPT + 1);

	// Signed width that holds an edge, a far edge and their differences.
	localparam int EXT_W  = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;
	localparam int AREA_W = 2 * DIM_W;
	localparam int UNI_W  = AREA_W + 1;
	localparam int OPA_W  = (THR_W > DIM_W) ? THR_W : DIM_W;
	localparam int OPB_W  = UNI_W;
	localparam int PROD_W = OPA_W + OPB_W;

	localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [DIM_W-1:0]             w;
		logic [DIM_W-1:0]             h;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AREA,
		ST_RD,
		ST_OVL,
		ST_MINT,
		ST_MAREA,
		ST_MTHR,
		ST_CMP,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		MUL_AREA_A,
		MUL_INTER,
		MUL_AREA_B,
		MUL_THR
	} mul_sel_t;

	typedef struct packed {
		logic     load_box;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     cap_area;
		logic     cap_ovl;
		logic     cap_inter;
		logic     cap_uni;
	} ctrl_t;

	// Low COORD_BITS bits of an edge field, zero-filled when wider than the field.
	function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [EDGE_W-1:0] v);
		logic [COORD_BITS+EDGE_W-1:0] t;
		t = {{COORD_BITS{1'b0}}, v};
		return t[COORD_BITS-1:0];
	endfunction

	// Low SLOT_W bits of a list position.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0] c);
		logic [CNT_W+SLOT_W-1:0] t;
		t = {{SLOT_W{1'b0}}, c};
		return t[SLOT_W-1:0];
	endfunction

endpackage

FILE: hdl/gbs_ifs.sv
// Channel interfaces: input boxes, results and the threshold write port.
interface gbs_box_if import gbs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     frame_start;
	logic signed [EDGE_W-1:0] box_x;
	logic signed [EDGE_W-1:0] box_y;
	logic [DIM_W-1:0]         box_w;
	logic [DIM_W-1:0]         box_h;

	modport source(output valid, frame_start, box_x, box_y, box_w, box_h, input ready);
	modport sink(input valid, frame_start, box_x, box_y, box_w, box_h, output ready);
endinterface

interface gbs_res_if import gbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              keep;
	logic [SLOT_W-1:0] kept_slot;
	logic              list_full;

	modport source(output valid, keep, kept_slot, list_full, input ready);
	modport sink(input valid, keep, kept_slot, list_full, output ready);
endinterface

interface gbs_cfg_if import gbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [THR_W-1:0] iou_threshold;

	modport source(output valid, iou_threshold, input ready);
	modport sink(input valid, iou_threshold, output ready);
endinterface

FILE: hdl/gbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/gbs_arith.sv
// Overlap stage and the shared multiplier that evaluates the overlap ratio test.
module gbs_arith import gbs_pkg::*; (
	input  logic             clk,
	input  ctrl_t            ctrl,
	input  box_t             new_box,
	input  box_t             rd_box,
	input  logic [THR_W-1:0] thr,
	output box_t             nb,
	output logic             suppress
);

	box_t              nb_q;
	logic [AREA_W-1:0] area_a_q;
	logic [AREA_W-1:0] inter_q;
	logic [DIM_W-1:0]  iw_q;
	logic [DIM_W-1:0]  ih_q;
	logic [DIM_W-1:0]  bw_q;
	logic [DIM_W-1:0]  bh_q;
	logic              uni_nz_q;
	logic [PROD_W-1:0] prod_q;

	logic [UNI_W-1:0] uni;
	logic [OPA_W-1:0] mul_a;
	logic [OPB_W-1:0] mul_b;
	logic [DIM_W-1:0] iw;
	logic [DIM_W-1:0] ih;

	// Length of the overlap of [a0, a0+al) and [b0, b0+bl), zero when empty.
	function automatic logic [DIM_W-1:0] ovl_len(
		input logic signed [COORD_BITS-1:0] a0,
		input logic [DIM_W-1:0]             al,
		input logic signed [COORD_BITS-1:0] b0,
		input logic [DIM_W-1:0]             bl
	);
		logic signed [EXT_W-1:0] ea0;
		logic signed [EXT_W-1:0] eb0;
		logic signed [EXT_W-1:0] ae;
		logic signed [EXT_W-1:0] be;
		logic signed [EXT_W-1:0] lo;
		logic signed [EXT_W-1:0] hi;
		logic signed [EXT_W-1:0] d;
		ea0 = EXT_W'(a0);
		eb0 = EXT_W'(b0);
		ae  = ea0 + EXT_W'($signed({1'b0, al}));
		be  = eb0 + EXT_W'($signed({1'b0, bl}));
		lo  = (ea0 > eb0) ? ea0 : eb0;
		hi  = (ae < be) ? ae : be;
		d   = hi - lo;
		return (hi > lo) ? d[DIM_W-1:0] : '0;
	endfunction

	assign iw  = ovl_len(nb_q.x, nb_q.w, rd_box.x, rd_box.w);
	assign ih  = ovl_len(nb_q.y, nb_q.h, rd_box.y, rd_box.h);
	assign uni = UNI_W'(area_a_q) + UNI_W'(prod_q[AREA_W-1:0]) - UNI_W'(inter_q);

	always_comb begin
		case (ctrl.mul_sel)
			MUL_AREA_A: begin
				mul_a = OPA_W'(nb_q.w);
				mul_b = OPB_W'(nb_q.h);
			end
			MUL_INTER: begin
				mul_a = OPA_W'(iw_q);
				mul_b = OPB_W'(ih_q);
			end
			MUL_AREA_B: begin
				mul_a = OPA_W'(bw_q);
				mul_b = OPB_W'(bh_q);
			end
			default: begin
				mul_a = OPA_W'(thr);
				mul_b = uni;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_box) begin
			nb_q <= new_box;
		end
		if (ctrl.cap_area) begin
			area_a_q <= prod_q[AREA_W-1:0];
		end
		if (ctrl.cap_ovl) begin
			iw_q <= iw;
			ih_q <= ih;
			bw_q <= rd_box.w;
			bh_q <= rd_box.h;
		end
		if (ctrl.cap_inter) begin
			inter_q <= prod_q[AREA_W-1:0];
		end
		if (ctrl.cap_uni) begin
			uni_nz_q <= (uni != '0);
		end
		if (ctrl.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Suppress when inter * 2^16 exceeds threshold * union, and only for a nonzero union.
	assign suppress = uni_nz_q && (PROD_W'({inter_q, {THR_W{1'b0}}}) > prod_q);
	assign nb       = nb_q;

endmodule

FILE: hdl/gbs_seq.sv
// Sequencer: walks the kept list through the shared unit and issues one result per box.
module gbs_seq import gbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	gbs_box_if.sink          box,
	gbs_res_if.source        result,
	input  logic             suppress,
	output ctrl_t            ctrl,
	output logic             ram_we,
	output logic [IDX_W-1:0] ram_waddr,
	output logic [IDX_W-1:0] ram_raddr
);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              keep_q, keep_d;
	logic              out_valid_q, out_valid_d;
	logic              out_keep_q, out_keep_d;
	logic [SLOT_W-1:0] out_slot_q, out_slot_d;
	logic              out_full_q, out_full_d;
	logic [CNT_W-1:0]  nxt;

	assign nxt       = CNT_W'(idx_q) + CNT_W'(1);
	assign ram_waddr = cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			keep_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			cnt_q       <= cnt_d;
			keep_q      <= keep_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_keep_q <= out_keep_d;
		out_slot_q <= out_slot_d;
		out_full_q <= out_full_d;
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		cnt_d        = cnt_q;
		keep_d       = keep_q;
		out_valid_d  = out_valid_q && !result.ready;
		out_keep_d   = out_keep_q;
		out_slot_d   = out_slot_q;
		out_full_d   = out_full_q;
		ctrl         = '0;
		ctrl.mul_sel = MUL_AREA_A;
		box.ready    = 1'b0;
		ram_we       = 1'b0;
		ram_raddr    = idx_q;

		unique case (state_q)
			ST_IDLE: begin
				box.ready = 1'b1;
				if (box.valid) begin
					ctrl.load_box = 1'b1;
					keep_d        = 1'b1;
					idx_d         = '0;
					if (box.frame_start) begin
						cnt_d = '0;
					end
					state_d = ST_AREA;
				end
			end
			ST_AREA: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_AREA_A;
				state_d      = (cnt_q == '0) ? ST_FIN : ST_RD;
			end
			ST_RD: begin
				ctrl.cap_area = 1'b1;
				state_d       = ST_OVL;
			end
			ST_OVL: begin
				ctrl.cap_ovl = 1'b1;
				state_d      = ST_MINT;
			end
			ST_MINT: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_INTER;
				state_d      = ST_MAREA;
			end
			ST_MAREA: begin
				ctrl.cap_inter = 1'b1;
				ctrl.mul_en    = 1'b1;
				ctrl.mul_sel   = MUL_AREA_B;
				state_d        = ST_MTHR;
			end
			ST_MTHR: begin
				ctrl.cap_uni = 1'b1;
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_THR;
				state_d      = ST_CMP;
			end
			ST_CMP: begin
				if (suppress) begin
					keep_d  = 1'b0;
					state_d = ST_FIN;
				end else if (nxt < cnt_q) begin
					idx_d     = IDX_W'(nxt);
					ram_raddr = IDX_W'(nxt);
					state_d   = ST_OVL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || result.ready) begin
					out_valid_d = 1'b1;
					out_keep_d  = keep_q;
					out_slot_d  = '0;
					out_full_d  = 1'b0;
					if (keep_q) begin
						if (cnt_q < CNT_W'(MAX_KEPT)) begin
							ram_we     = 1'b1;
							out_slot_d = slot_of(cnt_q);
							cnt_d      = cnt_q + CNT_W'(1);
						end else begin
							out_full_d = 1'b1;
						end
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result.valid     = out_valid_q;
	assign result.keep      = out_keep_q;
	assign result.kept_slot = out_slot_q;
	assign result.list_full = out_full_q;

endmodule

FILE: hdl/greedy_box_suppression_unit.sv
// Top level of the greedy box suppression unit: threshold register, list memory and datapath.
// A box against an empty list goes from its area step straight to the result; otherwise each
// kept box takes a pass of the overlap, multiply and compare states, ending early at the first
// suppressing box. Boxes are taken one at a time, the next once the result register is loaded;
// the pass of the shared multiplier per kept box sets the rate.
// Reset: arst_n empties the kept list and restores the threshold to 29491; the list memory
// itself is not cleared since only entries below the fill count are ever read.
module greedy_box_suppression_unit import gbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gbs_box_if.sink   box,
	gbs_res_if.source result,
	gbs_cfg_if.sink   cfg
);

	// The register takes every threshold write; writing only while idle is the user's duty.
	logic [THR_W-1:0] thr_q;

	ctrl_t            ctrl;
	box_t             new_box;
	box_t             nb;
	box_t             rd_box;
	logic [BOX_W-1:0] rd_word;
	logic             suppress;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.iou_threshold;
		end
	end

	// Edges keep their low COORD_BITS bits and are treated as signed from there.
	assign new_box.x = coord_of(box.box_x);
	assign new_box.y = coord_of(box.box_y);
	assign new_box.w = box.box_w;
	assign new_box.h = box.box_h;

	// Sequencer: accepts a box, steps through the kept list and loads the result register.
	// The result register lets the next box start while a result waits.
	gbs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.box       (box),
		.result    (result),
		.suppress  (suppress),
		.ctrl      (ctrl),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr)
	);

	// Kept list; a surviving box is written at the current fill count while the list has room.
	gbs_ram #(
		.WIDTH (BOX_W),
		.DEPTH (MAX_KEPT)
	) u_list (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (nb),
		.raddr (ram_raddr),
		.rdata (rd_word)
	);

	assign rd_box = box_t'(rd_word);

	// Overlap logic and the shared multiplier that forms the areas and the threshold product.
	gbs_arith u_arith (
		.clk      (clk),
		.ctrl     (ctrl),
		.new_box  (new_box),
		.rd_box   (rd_box),
		.thr      (thr_q),
		.nb       (nb),
		.suppress (suppress)
	);

endmodule
